// ===== rtl/core/psk_pkg.sv =====
// Shared types and constants for the scan code key decoder.
package psk_pkg;

    localparam int NUM_CONSOLES = 8;
    localparam int MAP_ROWS     = 128;
    localparam int MAP_COLUMNS  = 6;
    localparam int TABLE_SIZE   = MAP_ROWS * MAP_COLUMNS;
    localparam int MAP_ADDR_W   = $clog2(TABLE_SIZE);
    localparam int MAP_INDEX_W  = 10;
    localparam int MAP_WORD_W   = 16;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam logic [M_TUSER_W-1:0] KIND_CHAR    = 2'd0;
    localparam logic [M_TUSER_W-1:0] KIND_CONSOLE = 2'd1;
    localparam logic [M_TUSER_W-1:0] KIND_LED     = 2'd2;

    localparam logic [7:0] ASCII_ESC     = 8'h1B;
    localparam logic [7:0] ASCII_BRACKET = 8'h5B;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_CHAR,
        RES_CONSOLE,
        RES_LED,
        RES_PAD
    } res_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATTR,
        ST_COL,
        ST_CLASS,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [5:0] mod_mask;
        logic [2:0] lock_mask;
        logic       set_esc;
        res_e_t     res;
        logic [7:0] value;
    } dec_t;

    function automatic logic [MAP_ADDR_W-1:0] map_base(input logic [6:0] code);
        logic [MAP_ADDR_W+3:0] prod;
        prod = {{(MAP_ADDR_W-3){1'b0}}, code} * (MAP_ADDR_W + 4)'(MAP_COLUMNS);
        return prod[MAP_ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ps2_scancode_key_decoder_core.sv =====
// Top level of the scan code set 1 key decoder with its keymap sequencer.
//
// Items arrive as stream transfers: tuser selects a scan byte (0) or a keymap
// write (1). A keymap write, a prefix byte or a byte inside an unfinished
// sequence is taken in its transfer cycle and leaves the decoder idle. A byte
// that completes a code starts decoding: every decoded code passes through
// attribute read, column read and classification, then an emit step for each
// result that it produces, and a closing step releases the final result, if
// any. A result that the output cannot take stalls the emit and closing steps
// until m_tready frees the output register. The two reads are separate steps
// as the keymap RAM has a single registered read port, through which both
// reads of every code pass in turn. Each result waits in a holding register
// until the next one is known, so tlast can be set on the final one. The
// keymap has no clearing pass; entries must be written before use.
module ps2_scancode_key_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // scan_byte [7:0], map_index [17:8], map_word [33:18], zero fill above
    input  logic [psk_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  logic [psk_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value [7:0]
    output logic [psk_pkg::M_TDATA_W-1:0] m_tdata,
    // kind [1:0]
    output logic [psk_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import psk_pkg::*;

    localparam logic [7:0] PREFIX_E0 = 8'hE0;
    localparam logic [7:0] PREFIX_E1 = 8'hE1;

    state_t     state_reg, state_next;
    logic [7:0] seq_reg [3];
    logic [7:0] seq_next [3];
    logic [1:0] remain_reg, remain_next;
    logic [1:0] len_reg, len_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic [5:0] mods_reg, mods_next;
    logic       esc_reg, esc_next;
    logic [2:0] locks_reg, locks_next;
    logic [2:0] down_reg, down_next;
    res_e_t     res_reg, res_next;
    logic [7:0] resval_reg, resval_next;
    logic [1:0] padpos_reg, padpos_next;
    logic       hold_valid_reg, hold_valid_next;
    logic [M_TUSER_W-1:0] hold_kind_reg, hold_kind_next;
    logic [7:0] hold_value_reg, hold_value_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    logic                    in_xfer;
    logic [7:0]              in_byte;
    logic [MAP_INDEX_W-1:0]  in_index;
    logic [MAP_WORD_W-1:0]   in_word;
    logic                    ram_we;
    logic [MAP_ADDR_W-1:0]   ram_rd_addr;
    logic [MAP_WORD_W-1:0]   ram_rd_data;
    logic [MAP_ADDR_W-1:0]   base_addr;
    logic [MAP_ADDR_W-1:0]   col_addr;
    logic [7:0]              cur_code;
    dec_t                    dec;
    logic                    out_free;
    logic                    can_push;
    logic [M_TUSER_W-1:0]    new_kind;
    logic [7:0]              new_value;
    logic [2:0]              idx_inc;
    logic                    more_codes;
    logic                    lock_toggle;
    logic [2:0]              locks_tog;

    assign in_byte  = s_tdata[7:0];
    assign in_index = s_tdata[17:8];
    assign in_word  = s_tdata[33:18];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign ram_we   = in_xfer && s_tuser[0] && (in_index < MAP_INDEX_W'(TABLE_SIZE));
    assign cur_code = seq_reg[idx_reg];
    assign ram_rd_addr = (state_reg == ST_COL) ? col_addr : base_addr;

    psk_ram #(
        .WIDTH(MAP_WORD_W),
        .DEPTH(TABLE_SIZE)
    ) u_keymap (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (in_index[MAP_ADDR_W-1:0]),
        .wr_data (in_word),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    psk_decoder u_decoder (
        .code      (cur_code[6:0]),
        .make      (!cur_code[7]),
        .esc       (esc_reg),
        .mods      (mods_reg),
        .locks     (locks_reg),
        .ram_word  (ram_rd_data),
        .base_addr (base_addr),
        .col_addr  (col_addr),
        .dec       (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seq_reg[0]     <= '0;
            seq_reg[1]     <= '0;
            seq_reg[2]     <= '0;
            remain_reg     <= '0;
            len_reg        <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            mods_reg       <= '0;
            esc_reg        <= 1'b0;
            locks_reg      <= '0;
            down_reg       <= '0;
            padpos_reg     <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            seq_reg        <= seq_next;
            remain_reg     <= remain_next;
            len_reg        <= len_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            mods_reg       <= mods_next;
            esc_reg        <= esc_next;
            locks_reg      <= locks_next;
            down_reg       <= down_next;
            padpos_reg     <= padpos_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg        <= res_next;
        resval_reg     <= resval_next;
        hold_kind_reg  <= hold_kind_next;
        hold_value_reg <= hold_value_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    always_comb begin
        out_free   = !m_tvalid_reg || m_tready;
        can_push   = !hold_valid_reg || out_free;
        idx_inc    = {1'b0, idx_reg} + 3'd1;
        more_codes = idx_inc < {1'b0, cnt_reg};
        lock_toggle = !cur_code[7] && ((down_reg & dec.lock_mask) == 3'd0);
        locks_tog  = locks_reg ^ dec.lock_mask;

        new_kind  = KIND_CHAR;
        new_value = resval_reg;
        case (res_reg)
            RES_CONSOLE: new_kind = KIND_CONSOLE;
            RES_LED:     new_kind = KIND_LED;
            RES_PAD: begin
                if (padpos_reg == 2'd0) begin
                    new_value = ASCII_ESC;
                end else if (padpos_reg == 2'd1) begin
                    new_value = ASCII_BRACKET;
                end
            end
            default: new_kind = KIND_CHAR;
        endcase

        state_next      = state_reg;
        seq_next        = seq_reg;
        remain_next     = remain_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        mods_next       = mods_reg;
        esc_next        = esc_reg;
        locks_next      = locks_reg;
        down_next       = down_reg;
        res_next        = res_reg;
        resval_next     = resval_reg;
        padpos_next     = padpos_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_value_next = hold_value_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && !s_tuser[0]) begin
                    if (in_byte == PREFIX_E0) begin
                        seq_next[0] = PREFIX_E0;
                        remain_next = 2'd1;
                        len_next    = 2'd1;
                    end else if (in_byte == PREFIX_E1) begin
                        seq_next[0] = PREFIX_E1;
                        remain_next = 2'd2;
                        len_next    = 2'd1;
                    end else if (remain_reg != 2'd0) begin
                        if (len_reg < 2'd3) begin
                            seq_next[len_reg] = in_byte;
                        end
                        len_next    = len_reg + 2'd1;
                        remain_next = remain_reg - 2'd1;
                        if (remain_reg == 2'd1) begin
                            cnt_next   = (len_next == 2'd3) ? 2'd3 : 2'd2;
                            idx_next   = 2'd0;
                            state_next = ST_ATTR;
                        end
                    end else begin
                        seq_next[0] = in_byte;
                        cnt_next    = 2'd1;
                        idx_next    = 2'd0;
                        state_next  = ST_ATTR;
                    end
                end
            end
            ST_ATTR: begin
                state_next = ST_COL;
            end
            ST_COL: begin
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                esc_next    = dec.set_esc;
                padpos_next = 2'd0;
                res_next    = dec.res;
                resval_next = dec.value;
                if (dec.mod_mask != 6'd0) begin
                    mods_next = cur_code[7] ? (mods_reg & ~dec.mod_mask)
                                            : (mods_reg | dec.mod_mask);
                end
                if (dec.lock_mask != 3'd0) begin
                    down_next = cur_code[7] ? (down_reg & ~dec.lock_mask)
                                            : (down_reg | dec.lock_mask);
                    if (lock_toggle) begin
                        locks_next  = locks_tog;
                        res_next    = RES_LED;
                        resval_next = {5'd0, locks_tog};
                    end else begin
                        res_next = RES_NONE;
                    end
                end
                if (res_next != RES_NONE) begin
                    state_next = ST_EMIT;
                end else if (more_codes) begin
                    idx_next   = idx_inc[1:0];
                    state_next = ST_ATTR;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_EMIT: begin
                if (can_push) begin
                    if (hold_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = hold_kind_reg;
                        m_tdata_next  = hold_value_reg;
                        m_tlast_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_kind_next  = new_kind;
                    hold_value_next = new_value;
                    if (res_reg == RES_PAD && padpos_reg != 2'd2) begin
                        padpos_next = padpos_reg + 2'd1;
                    end else if (more_codes) begin
                        idx_next   = idx_inc[1:0];
                        state_next = ST_ATTR;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tuser_next    = hold_kind_reg;
                    m_tdata_next    = hold_value_reg;
                    m_tlast_next    = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("A result is still held while the decoder is idle.");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ({1'b0, idx_reg} < {1'b0, cnt_reg}))
        else $error("The code index has passed the sequence length.");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> (state_reg == ST_IDLE))
        else $error("A keymap write transfer started decoding.");

endmodule

// ===== rtl/core/psk_ram.sv =====
// Generic single-port-write, registered-read RAM.
module psk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/psk_decoder.sv =====
// Keymap column selection and classification of a mapped key entry.
module psk_decoder (
    input  logic [6:0]                     code,
    input  logic                           make,
    input  logic                           esc,
    input  logic [5:0]                     mods,
    input  logic [2:0]                     locks,
    input  logic [psk_pkg::MAP_WORD_W-1:0] ram_word,
    output logic [psk_pkg::MAP_ADDR_W-1:0] base_addr,
    output logic [psk_pkg::MAP_ADDR_W-1:0] col_addr,
    output psk_pkg::dec_t                  dec
);
    import psk_pkg::*;

    localparam logic [14:0] ENT_EXT      = 15'h0100;
    localparam logic [14:0] ENT_CTRL     = 15'h0200;
    localparam logic [14:0] ENT_SHIFT    = 15'h0400;
    localparam logic [14:0] ENT_ALT      = 15'h0800;
    localparam logic [14:0] ENT_ESCKEY   = 15'h1000;
    localparam logic [14:0] ENT_CAPSLOCK = ENT_EXT + 15'h0D;
    localparam logic [14:0] ENT_NUMLOCK  = ENT_EXT + 15'h0E;
    localparam logic [14:0] ENT_SCRLOCK  = ENT_EXT + 15'h0F;
    localparam logic [14:0] ENT_PAD_LO   = ENT_EXT + 15'h01;
    localparam logic [14:0] ENT_PAD_HI   = ENT_EXT + 15'h0C;
    localparam logic [14:0] ENT_ALT_F1   = ENT_ALT + 15'h10;
    localparam logic [14:0] ENT_ALT_ESC  = 15'h009B;
    localparam logic [14:0] ENT_ALT_END  = ENT_ALT_F1 + 15'(NUM_CONSOLES - 1);

    localparam logic [5:0] M_SHL = 6'h01;
    localparam logic [5:0] M_SHR = 6'h02;
    localparam logic [5:0] M_CTL = 6'h04;
    localparam logic [5:0] M_CTR = 6'h08;
    localparam logic [5:0] M_ALL = 6'h10;
    localparam logic [5:0] M_ALR = 6'h20;

    localparam logic [2:0] LK_SCROLL = 3'd1;
    localparam logic [2:0] LK_NUM    = 3'd2;
    localparam logic [2:0] LK_CAPS   = 3'd4;

    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_SLASH  = 7'h35;
    localparam logic [6:0] CODE_PAD_LO = 7'h47;
    localparam logic [6:0] CODE_PAD_HI = 7'h53;

    function automatic logic [7:0] pad_letter(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = "H";
            4'd1:    r = "Y";
            4'd2:    r = "A";
            4'd3:    r = "B";
            4'd4:    r = "D";
            4'd5:    r = "C";
            4'd6:    r = "V";
            4'd7:    r = "U";
            4'd8:    r = "G";
            4'd9:    r = "S";
            4'd10:   r = "T";
            default: r = "@";
        endcase
        return r;
    endfunction

    logic        sh;
    logic        ct;
    logic        al;
    logic        caps;
    logic [2:0]  col;
    logic [14:0] ch;
    logic [14:0] pad_off;
    logic [14:0] con_off;

    assign base_addr = map_base(code);
    assign col_addr  = base_addr + MAP_ADDR_W'(col);

    always_comb begin
        sh   = |mods[1:0];
        ct   = |mods[3:2];
        al   = |mods[5:4];
        caps = sh ^ (locks[1] && code >= CODE_PAD_LO && code <= CODE_PAD_HI)
                  ^ (locks[2] && ram_word[15]);
        if (al) begin
            col = caps ? 3'd4 : ((ct || mods[5]) ? 3'd3 : 3'd2);
        end else begin
            col = ct ? 3'd5 : (caps ? 3'd1 : 3'd0);
        end
    end

    always_comb begin
        ch      = (code == CODE_SLASH && esc) ? 15'h002F : ram_word[14:0];
        pad_off = ch - ENT_PAD_LO;
        con_off = ch - ENT_ALT_F1 + 15'd1;
        dec           = '0;
        dec.res       = RES_NONE;
        case (ch)
            ENT_CTRL:     dec.mod_mask  = esc ? M_CTR : M_CTL;
            ENT_SHIFT:    dec.mod_mask  = (code == CODE_RSHIFT) ? M_SHR : M_SHL;
            ENT_ALT:      dec.mod_mask  = esc ? M_ALR : M_ALL;
            ENT_CAPSLOCK: dec.lock_mask = LK_CAPS;
            ENT_NUMLOCK:  dec.lock_mask = LK_NUM;
            ENT_SCRLOCK:  dec.lock_mask = LK_SCROLL;
            ENT_ESCKEY:   dec.set_esc   = 1'b1;
            default: begin
                if (make) begin
                    if (ch == ENT_ALT_ESC) begin
                        dec.res = RES_CONSOLE;
                    end else if (ch >= 15'd1 && ch <= 15'h00FF) begin
                        dec.res   = RES_CHAR;
                        dec.value = ch[7:0];
                    end else if (ch >= ENT_PAD_LO && ch <= ENT_PAD_HI) begin
                        dec.res   = RES_PAD;
                        dec.value = pad_letter(pad_off[3:0]);
                    end else if (ch >= ENT_ALT_F1 && ch < ENT_ALT_END) begin
                        dec.res   = RES_CONSOLE;
                        dec.value = con_off[7:0];
                    end
                end
            end
        endcase
    end

endmodule
